### rtl/first_fit_block_allocator_defines.svh
`ifndef FIRST_FIT_BLOCK_ALLOCATOR_DEFINES_SVH
`define FIRST_FIT_BLOCK_ALLOCATOR_DEFINES_SVH

// Same-cycle implication, sampled on clk and disabled while arst_n is low.
`define FFBA_ASSERT_NOW(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// Next-cycle implication, sampled on clk and disabled while arst_n is low.
`define FFBA_ASSERT_NEXT(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

### rtl/ffba_pkg.sv
package ffba_pkg;

	localparam int MAX_BLOCKS = 64;
	localparam int IDX_W = (MAX_BLOCKS > 1) ? $clog2(MAX_BLOCKS) : 1;
	localparam int CNT_W = $clog2(MAX_BLOCKS + 1);

	localparam logic ACT_ALLOC   = 1'b0;
	localparam logic ACT_RELEASE = 1'b1;

	localparam logic [1:0] REG_HEAP_BASE    = 2'd0;
	localparam logic [1:0] REG_HEAP_BYTES   = 2'd1;
	localparam logic [1:0] REG_HEADER_BYTES = 2'd2;

	typedef enum logic [2:0] {
		ST_OK        = 3'd0,
		ST_ZERO_SIZE = 3'd1,
		ST_EXHAUSTED = 3'd2,
		ST_FULL      = 3'd3,
		ST_UNKNOWN   = 3'd4
	} status_t;

	// Search item passed from cell to cell.
	typedef struct packed {
		logic        valid;
		logic        search;
		logic        action;
		logic [31:0] size;
		logic [31:0] target;
		logic        found;
		logic [31:0] off;
	} tok_t;

	// Entry write broadcast to all cells.
	typedef struct packed {
		logic             en;
		logic [IDX_W-1:0] idx;
		logic [31:0]      size;
		logic [31:0]      off;
	} wr_t;

endpackage

### rtl/first_fit_block_allocator.sv
// Each item walks the row of table cells, one cell per cycle, then is resolved in the finish state,
// which waits while out_stall holds the output. A new item is not accepted until the previous one
// has finished; in_stall is high meanwhile.
// Reset (arst_n low, asynchronous) empties the table and the heap and loads the default
// registers: base 4096, heap 65536 bytes, header 24 bytes.
`include "first_fit_block_allocator_defines.svh"

module first_fit_block_allocator
	import ffba_pkg::*;
(
	input  logic        clk,
	input  logic        arst_n,
	input  logic        cfg_valid,
	output logic        cfg_ready,
	input  logic [1:0]  cfg_index,
	input  logic [31:0] cfg_data,
	input  logic        in_valid,
	output logic        in_stall,
	input  logic        action,
	input  logic [31:0] request_size,
	input  logic [31:0] release_address,
	output logic        out_valid,
	input  logic        out_stall,
	output logic [31:0] payload_address,
	output logic [2:0]  status,
	output logic        reused
);

	typedef enum logic [1:0] {
		S_IDLE,
		S_WALK,
		S_FINISH
	} state_t;

	state_t           state_q;
	logic [31:0]      base_q;
	logic [31:0]      bytes_q;
	logic [7:0]       hdr_q;
	logic [CNT_W-1:0] count_q;
	logic [31:0]      top_q;
	logic [33:0]      end_q;
	tok_t             inj_q;
	tok_t             fin_q;
	logic             out_valid_q;
	logic [31:0]      addr_q;
	status_t          status_q;
	logic             reused_q;

	tok_t             tok [MAX_BLOCKS+1];
	wr_t              wr;
	logic             accept;
	logic             fire;
	logic             exhausted;
	logic             do_write;
	logic [31:0]      res_addr;
	status_t          res_status;
	logic             res_reused;

	assign cfg_ready = 1'b1;
	assign accept    = in_valid && !in_stall;
	assign in_stall  = (state_q != S_IDLE);
	assign tok[0]    = inj_q;

	for (genvar i = 0; i < MAX_BLOCKS; i++) begin : g_cell
		ffba_cell u_cell (
			.clk     (clk),
			.arst_n  (arst_n),
			.idx     (IDX_W'(i)),
			.count   (count_q),
			.wr      (wr),
			.tok_in  (tok[i]),
			.tok_out (tok[i+1])
		);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			base_q  <= 32'd4096;
			bytes_q <= 32'd65536;
			hdr_q   <= 8'd24;
		end else if (cfg_valid && cfg_ready) begin
			case (cfg_index)
				REG_HEAP_BASE:    base_q  <= cfg_data;
				REG_HEAP_BYTES:   bytes_q <= cfg_data;
				REG_HEADER_BYTES: hdr_q   <= cfg_data[7:0];
				default: ;
			endcase
		end
	end

	assign exhausted = (end_q > {2'b00, bytes_q}) ||
		(({2'b00, base_q} + end_q) > 34'h1_0000_0000);

	always_comb begin
		res_addr   = 32'd0;
		res_status = ST_OK;
		res_reused = 1'b0;
		do_write   = 1'b0;
		if (fin_q.action == ACT_ALLOC) begin
			if (!fin_q.search) begin
				res_status = ST_ZERO_SIZE;
			end else if (fin_q.found) begin
				res_addr   = base_q + fin_q.off + {24'd0, hdr_q};
				res_reused = 1'b1;
			end else if (exhausted) begin
				res_status = ST_EXHAUSTED;
			end else if (count_q == CNT_W'(MAX_BLOCKS)) begin
				res_status = ST_FULL;
			end else begin
				do_write = 1'b1;
				res_addr = base_q + top_q + {24'd0, hdr_q};
			end
		end else if (fin_q.search && !fin_q.found) begin
			res_status = ST_UNKNOWN;
		end
	end

	assign fire = (state_q == S_FINISH) && (!out_valid_q || !out_stall);

	always_comb begin
		wr.en   = fire && do_write;
		wr.idx  = count_q[IDX_W-1:0];
		wr.size = fin_q.size;
		wr.off  = top_q;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_IDLE;
			count_q     <= '0;
			top_q       <= 32'd0;
			end_q       <= 34'd0;
			inj_q       <= '0;
			fin_q       <= '0;
			out_valid_q <= 1'b0;
			addr_q      <= 32'd0;
			status_q    <= ST_OK;
			reused_q    <= 1'b0;
		end else begin
			inj_q.valid <= accept;
			if (fire) begin
				out_valid_q <= 1'b1;
			end else if (out_valid_q && !out_stall) begin
				out_valid_q <= 1'b0;
			end
			case (state_q)
				S_IDLE: begin
					if (accept) begin
						inj_q.action <= action;
						inj_q.size   <= request_size;
						inj_q.target <= release_address - base_q - {24'd0, hdr_q};
						inj_q.found  <= 1'b0;
						inj_q.off    <= 32'd0;
						inj_q.search <= (action == ACT_ALLOC) ? (request_size != 32'd0)
							: (release_address != 32'd0);
						end_q   <= {2'b00, top_q} + {26'd0, hdr_q} + {2'b00, request_size};
						state_q <= S_WALK;
					end
				end
				S_WALK: begin
					if (tok[MAX_BLOCKS].valid) begin
						fin_q   <= tok[MAX_BLOCKS];
						state_q <= S_FINISH;
					end
				end
				S_FINISH: begin
					if (fire) begin
						addr_q   <= res_addr;
						status_q <= res_status;
						reused_q <= res_reused;
						if (do_write) begin
							count_q <= count_q + CNT_W'(1);
							top_q   <= end_q[31:0];
						end
						state_q <= S_IDLE;
					end
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end

	assign out_valid       = out_valid_q;
	assign payload_address = addr_q;
	assign status          = status_q;
	assign reused          = reused_q;

	`FFBA_ASSERT_NOW(a_tok_in_walk, tok[MAX_BLOCKS].valid, state_q == S_WALK, "item left the cell row outside the walk")
	`FFBA_ASSERT_NOW(a_write_not_found, wr.en, !fin_q.found && (fin_q.action == ACT_ALLOC), "new entry written for a found or released block")
	`FFBA_ASSERT_NEXT(a_count_step, wr.en, count_q == $past(count_q) + CNT_W'(1), "entry count did not advance on a write")

endmodule

### rtl/ffba_cell.sv
module ffba_cell
	import ffba_pkg::*;
(
	input  logic             clk,
	input  logic             arst_n,
	input  logic [IDX_W-1:0] idx,
	input  logic [CNT_W-1:0] count,
	input  wr_t              wr,
	input  tok_t             tok_in,
	output tok_t             tok_out
);

	logic [31:0] size_q;
	logic [31:0] off_q;
	logic        free_q;
	logic        valid_q;
	tok_t        tok_q;
	tok_t        tok_d;
	logic        in_use;
	logic        hit;

	assign in_use = CNT_W'(idx) < count;

	always_comb begin
		hit = 1'b0;
		if (tok_in.valid && tok_in.search && !tok_in.found && in_use) begin
			if (tok_in.action == ACT_ALLOC) begin
				hit = free_q && (size_q >= tok_in.size);
			end else begin
				hit = (off_q == tok_in.target);
			end
		end
	end

	always_comb begin
		tok_d = tok_in;
		if (hit) begin
			tok_d.found = 1'b1;
			tok_d.off   = off_q;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			free_q  <= 1'b0;
			valid_q <= 1'b0;
		end else begin
			valid_q <= tok_in.valid;
			if (wr.en && (wr.idx == idx)) begin
				free_q <= 1'b0;
			end else if (hit) begin
				free_q <= (tok_in.action == ACT_RELEASE);
			end
		end
	end

	always_ff @(posedge clk) begin
		if (wr.en && (wr.idx == idx)) begin
			size_q <= wr.size;
			off_q  <= wr.off;
		end
		tok_q <= tok_d;
	end

	always_comb begin
		tok_out       = tok_q;
		tok_out.valid = valid_q;
	end

endmodule
